### rtl/ucb_bandit_arm_selector_top_defines.svh
// ----------------------------------------------------------------------------
// UCB bandit arm selector assertion macros
// Shared property forms for the checks in the bandit selector RTL.
// ----------------------------------------------------------------------------
`ifndef UCB_BANDIT_ARM_SELECTOR_TOP_DEFINES_SVH
`define UCB_BANDIT_ARM_SELECTOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define UCBAS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define UCBAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ucbas_pkg.sv
// ----------------------------------------------------------------------------
// UCB bandit arm selector package
// State encoding, fixed-point widths and constants of the selector.
// ----------------------------------------------------------------------------
package ucbas_pkg;

    // Natural log in Q.16 fits in 21 bits (31.99 * ln2)
    localparam int LN_W      = 21;
    localparam int LOG_STEPS = 16;
    // Square root operand q << 16 fits in 37 bits; one spare for res + bit
    localparam int SQ_W      = 38;
    localparam int SQ_STEPS  = 19;
    localparam int SCORE_W   = 24;
    localparam int EST_W     = 17;
    localparam int GAIN_W    = 16;
    localparam int ARMS_W    = 5;
    localparam int CFG_W     = 16;
    localparam int TOTAL_W   = 32;

    localparam logic [15:0]      LN2_Q16    = 16'd45426;
    localparam logic [EST_W-1:0] EST_HALF   = 17'd32768;
    localparam logic [EST_W-1:0] EST_ONE    = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
    localparam logic [ARMS_W-1:0] ARMS_RESET = 5'd16;

    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_ARMS = 1'b1;

    localparam logic MODE_CHOOSE = 1'b0;
    localparam logic MODE_REWARD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOG_NORM,
        S_LOG_MUL,
        S_LOG_STEP,
        S_LN_MUL,
        S_LN_DONE,
        S_ARM_FETCH,
        S_ARM_LOAD,
        S_DIV,
        S_SQRT,
        S_TERM_MUL,
        S_SCORE,
        S_COMMIT,
        S_UPD_FETCH,
        S_UPD_LOAD,
        S_UPD_WRITE
    } state_t;

endpackage

### rtl/ucbas_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ucbas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/ucb_bandit_arm_selector_top.sv
// ----------------------------------------------------------------------------
// UCB bandit arm selector
// Scores arms by estimate + c*sqrt(ln(round)/(pulls+1)) with one shared
// multiplier, a restoring divider and a bit-serial square root.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------
//  input   | s_mode, s_reward                        | s_valid/s_ready
//  result  | m_arm, m_arm_found, m_reward_accepted,  | m_valid/m_ready
//          | m_total_reward                          |
//  config  | cfg_index, cfg_data                     | cfg_we
//
// A choose word passes through the idle state, the leading-one shift, the log
// squaring and the ln scaling, then for each active arm a RAM read, a load,
// 21 divider steps, 19 square-root steps, a multiply and a compare, and last
// a commit. A reward word reads and loads the pending arm, runs the 21 divider
// steps and writes the estimate back before its commit; with nothing pending
// it goes straight to the commit. s_ready is high only when idle; commit
// stalls while the output register still holds an untaken word. Reset is
// synchronous and needs no clearing pass.
module ucb_bandit_arm_selector_top #(
    parameter int ARMS        = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic        s_reward,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_arm,
    output logic        m_arm_found,
    output logic        m_reward_accepted,
    output logic [31:0] m_total_reward,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import ucbas_pkg::*;

`include "ucb_bandit_arm_selector_top_defines.svh"

    localparam int ARM_W = (ARMS > 1) ? $clog2(ARMS) : 1;
    localparam int IDX_W = $clog2(ARMS + 1);
    localparam int DVW   = (COUNT_WIDTH + 1 > 32) ? COUNT_WIDTH + 1 : 32;
    localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << 36;

    // Control state
    state_t                   state_reg, state_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic [ARMS_W-1:0]        arms_reg, arms_next;
    logic [31:0]              round_reg, round_next;
    logic [31:0]              points_reg, points_next;
    logic [ARM_W-1:0]         pending_reg, pending_next;
    logic                     pend_vld_reg, pend_vld_next;
    logic [ARMS-1:0]          est_vld_reg, est_vld_next;
    logic [ARMS-1:0]          pull_vld_reg, pull_vld_next;
    logic                     m_valid_reg, m_valid_next;

    // Datapath
    logic [31:0]              m_reg, m_next;
    logic [4:0]               e_reg, e_next;
    logic [LOG_STEPS-1:0]     frac_reg, frac_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [LN_W-1:0]          ln_reg, ln_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [SCORE_W-1:0]       best_reg, best_next;
    logic [ARM_W-1:0]         pick_reg, pick_next;
    logic [COUNT_WIDTH-1:0]   pick_pull_reg, pick_pull_next;
    logic [COUNT_WIDTH-1:0]   cur_pull_reg, cur_pull_next;
    logic                     have_reg, have_next;
    logic [EST_W-1:0]         est_reg, est_next;
    logic [LN_W-1:0]          dvd_reg, dvd_next;
    logic [DVW-1:0]           rem_reg, rem_next;
    logic [DVW-1:0]           dvs_reg, dvs_next;
    logic [SQ_W-1:0]          sq_v_reg, sq_v_next;
    logic [SQ_W-1:0]          sq_res_reg, sq_res_next;
    logic [SQ_W-1:0]          sq_bit_reg, sq_bit_next;
    logic                     upd_reg, upd_next;
    logic                     rew_reg, rew_next;
    logic [63:0]              prod_reg;
    logic [3:0]               r_arm_reg, r_arm_next;
    logic                     r_acc_reg, r_acc_next;
    logic [3:0]               m_arm_reg, m_arm_next;
    logic                     m_found_reg, m_found_next;
    logic                     m_acc_reg, m_acc_next;
    logic [31:0]              m_total_reg, m_total_next;

    // Shared multiplier operands
    logic [31:0]              mul_a, mul_b;

    // Memories
    logic [ARM_W-1:0]         rd_addr;
    logic [EST_W-1:0]         est_rdata, est_wdata;
    logic [COUNT_WIDTH-1:0]   pull_rdata, pull_wdata;
    logic                     est_we, pull_we;

    // Step helpers
    logic [IDX_W-1:0]         active;
    logic [DVW:0]             rem_sh;
    logic                     div_ge;
    logic [SQ_W-1:0]          sq_t;
    logic                     sq_ge;
    logic [32:0]              sq_m;
    logic [SCORE_W-1:0]       score;
    logic [EST_W-1:0]         est_clamp;
    logic                     slot_free;

    // Check helpers
    logic                     chk_points_ok;
    logic                     chk_commit;
    logic                     chk_out_idle;
    logic                     chk_found_idle;

    ucbas_ram #(.WIDTH(EST_W), .DEPTH(ARMS)) u_est_ram (
        .aclk (aclk),
        .we   (est_we),
        .waddr(pending_reg),
        .wdata(est_wdata),
        .raddr(rd_addr),
        .rdata(est_rdata)
    );

    ucbas_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ARMS)) u_pull_ram (
        .aclk (aclk),
        .we   (pull_we),
        .waddr(pick_reg),
        .wdata(pull_wdata),
        .raddr(rd_addr),
        .rdata(pull_rdata)
    );

    // Clamp arm count to the array size
    assign active = (32'(arms_reg) > ARMS) ? IDX_W'(ARMS) : IDX_W'(arms_reg);
    assign rd_addr = (state_reg == S_UPD_FETCH) ? pending_reg : idx_reg[ARM_W-1:0];

    // Restoring divider step
    assign rem_sh = {rem_reg, dvd_reg[LN_W-1]};
    assign div_ge = rem_sh >= {1'b0, dvs_reg};

    // Square-root step
    assign sq_t  = sq_res_reg + sq_bit_reg;
    assign sq_ge = sq_v_reg >= sq_t;

    // Log squaring and score
    assign sq_m  = prod_reg[63:31];
    assign score = SCORE_W'(est_reg) + SCORE_W'(prod_reg[34:12]);
    assign est_clamp = (est_rdata > EST_ONE) ? EST_ONE : est_rdata;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);

    assign m_valid           = m_valid_reg;
    assign m_arm             = m_arm_reg;
    assign m_arm_found       = m_found_reg;
    assign m_reward_accepted = m_acc_reg;
    assign m_total_reward    = m_total_reg;

    // Pick multiplier operands
    always_comb begin
        case (state_reg)
            S_LOG_MUL: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_LN_MUL: begin
                mul_a = 32'({e_reg, frac_reg});
                mul_b = 32'(LN2_Q16);
            end
            default: begin
                mul_a = 32'(gain_reg);
                mul_b = 32'(sq_res_reg[SQ_STEPS-1:0]);
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        arms_next      = arms_reg;
        round_next     = round_reg;
        points_next    = points_reg;
        pending_next   = pending_reg;
        pend_vld_next  = pend_vld_reg;
        est_vld_next   = est_vld_reg;
        pull_vld_next  = pull_vld_reg;
        m_valid_next   = m_valid_reg;
        m_next         = m_reg;
        e_next         = e_reg;
        frac_next      = frac_reg;
        cnt_next       = cnt_reg;
        ln_next        = ln_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        pick_pull_next = pick_pull_reg;
        cur_pull_next  = cur_pull_reg;
        have_next      = have_reg;
        est_next       = est_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        sq_v_next      = sq_v_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        upd_next       = upd_reg;
        rew_next       = rew_reg;
        r_arm_next     = r_arm_reg;
        r_acc_next     = r_acc_reg;
        m_arm_next     = m_arm_reg;
        m_found_next   = m_found_reg;
        m_acc_next     = m_acc_reg;
        m_total_next   = m_total_reg;
        est_we         = 1'b0;
        est_wdata      = est_reg;
        pull_we        = 1'b0;
        pull_wdata     = (pick_pull_reg == '1) ? pick_pull_reg : pick_pull_reg + 1'b1;

        // Drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_we) begin
            case (cfg_index)
                CFG_GAIN: gain_next = cfg_data[GAIN_W-1:0];
                CFG_ARMS: arms_next = cfg_data[ARMS_W-1:0];
                default:  gain_next = gain_reg;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    r_arm_next   = '0;
                    r_acc_next   = 1'b0;
                    rew_next     = s_reward;
                    if (s_mode == MODE_CHOOSE) begin
                        upd_next  = 1'b0;
                        m_next    = round_reg;
                        e_next    = 5'd31;
                        frac_next = '0;
                        cnt_next  = '0;
                        state_next = (round_reg == '0) ? S_LN_MUL : S_LOG_NORM;
                        if (round_reg == '0) begin
                            e_next = '0;
                        end
                    end else begin
                        upd_next   = 1'b1;
                        state_next = pend_vld_reg ? S_UPD_FETCH : S_COMMIT;
                    end
                end
            end
            // Shift to the leading one
            S_LOG_NORM: begin
                if (m_reg[31]) begin
                    state_next = S_LOG_MUL;
                end else begin
                    m_next = {m_reg[30:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            S_LOG_MUL: begin
                state_next = S_LOG_STEP;
            end
            // Square the mantissa, take one fraction bit
            S_LOG_STEP: begin
                frac_next = {frac_reg[LOG_STEPS-2:0], sq_m[32]};
                m_next    = sq_m[32] ? sq_m[32:1] : sq_m[31:0];
                cnt_next  = cnt_reg + 1'b1;
                state_next = (cnt_reg == 5'(LOG_STEPS - 1)) ? S_LN_MUL : S_LOG_MUL;
            end
            S_LN_MUL: begin
                state_next = S_LN_DONE;
            end
            S_LN_DONE: begin
                ln_next   = prod_reg[LN_W+15:16];
                idx_next  = '0;
                best_next = '0;
                have_next = 1'b0;
                pick_next = '0;
                state_next = (active == '0) ? S_COMMIT : S_ARM_FETCH;
            end
            S_ARM_FETCH: begin
                state_next = S_ARM_LOAD;
            end
            // Load arm state, start divide ln / (pulls + 1)
            S_ARM_LOAD: begin
                cur_pull_next = pull_vld_reg[idx_reg[ARM_W-1:0]] ? pull_rdata : '0;
                est_next = est_vld_reg[idx_reg[ARM_W-1:0]] ? est_rdata : EST_HALF;
                dvs_next = DVW'(pull_vld_reg[idx_reg[ARM_W-1:0]] ? pull_rdata : '0)
                           + DVW'(1);
                dvd_next = ln_reg;
                rem_next = '0;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next = div_ge ? DVW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVW-1:0];
                dvd_next = {dvd_reg[LN_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(LN_W - 1)) begin
                    if (upd_reg) begin
                        state_next = S_UPD_WRITE;
                    end else begin
                        sq_v_next   = SQ_W'({dvd_reg[LN_W-2:0], div_ge, 16'b0});
                        sq_res_next = '0;
                        sq_bit_next = SQ_BIT0;
                        cnt_next    = '0;
                        state_next  = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                sq_v_next   = sq_ge ? sq_v_reg - sq_t : sq_v_reg;
                sq_res_next = sq_ge ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == 5'(SQ_STEPS - 1)) begin
                    state_next = S_TERM_MUL;
                end
            end
            S_TERM_MUL: begin
                state_next = S_SCORE;
            end
            // Keep the first strictly greatest score
            S_SCORE: begin
                if (score > best_reg) begin
                    best_next      = score;
                    pick_next      = idx_reg[ARM_W-1:0];
                    pick_pull_next = cur_pull_reg;
                    have_next      = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 < active) ? S_ARM_FETCH : S_COMMIT;
            end
            S_UPD_FETCH: begin
                state_next = S_UPD_LOAD;
            end
            S_UPD_LOAD: begin
                est_next = est_vld_reg[pending_reg] ? est_clamp : EST_HALF;
                dvd_next = LN_W'(rew_reg ? EST_ONE - (est_vld_reg[pending_reg] ?
                           est_clamp : EST_HALF) : (est_vld_reg[pending_reg] ?
                           est_clamp : EST_HALF));
                dvs_next = (round_reg == '0) ? DVW'(1) : DVW'(round_reg);
                rem_next = '0;
                cnt_next = '0;
                state_next = S_DIV;
            end
            // Move the estimate toward the reward
            S_UPD_WRITE: begin
                est_we    = 1'b1;
                est_wdata = rew_reg ? est_reg + dvd_reg[EST_W-1:0]
                                    : est_reg - dvd_reg[EST_W-1:0];
                est_vld_next[pending_reg] = 1'b1;
                pend_vld_next = 1'b0;
                if (round_reg != '1) begin
                    round_next = round_reg + 1'b1;
                end
                if (rew_reg && points_reg != '1) begin
                    points_next = points_reg + 1'b1;
                end
                r_acc_next = 1'b1;
                state_next = S_COMMIT;
            end
            // Count the pull of a found arm and hand the word to the output register
            S_COMMIT: begin
                if (slot_free) begin
                    if (!upd_reg && have_reg) begin
                        pull_we = 1'b1;
                        pull_vld_next[pick_reg] = 1'b1;
                        pending_next  = pick_reg;
                        pend_vld_next = 1'b1;
                    end
                    m_arm_next   = (!upd_reg && have_reg) ? 4'(pick_reg) : r_arm_reg;
                    m_found_next = !upd_reg && have_reg;
                    m_acc_next   = r_acc_reg;
                    m_total_next = points_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            gain_reg     <= GAIN_RESET;
            arms_reg     <= ARMS_RESET;
            round_reg    <= 32'd1;
            points_reg   <= '0;
            pending_reg  <= '0;
            pend_vld_reg <= 1'b0;
            est_vld_reg  <= '0;
            pull_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gain_reg     <= gain_next;
            arms_reg     <= arms_next;
            round_reg    <= round_next;
            points_reg   <= points_next;
            pending_reg  <= pending_next;
            pend_vld_reg <= pend_vld_next;
            est_vld_reg  <= est_vld_next;
            pull_vld_reg <= pull_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg      <= mul_a * mul_b;
        m_reg         <= m_next;
        e_reg         <= e_next;
        frac_reg      <= frac_next;
        cnt_reg       <= cnt_next;
        ln_reg        <= ln_next;
        idx_reg       <= idx_next;
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        pick_pull_reg <= pick_pull_next;
        cur_pull_reg  <= cur_pull_next;
        have_reg      <= have_next;
        est_reg       <= est_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        sq_v_reg      <= sq_v_next;
        sq_res_reg    <= sq_res_next;
        sq_bit_reg    <= sq_bit_next;
        upd_reg       <= upd_next;
        rew_reg       <= rew_next;
        r_arm_reg     <= r_arm_next;
        r_acc_reg     <= r_acc_next;
        m_arm_reg     <= m_arm_next;
        m_found_reg   <= m_found_next;
        m_acc_reg     <= m_acc_next;
        m_total_reg   <= m_total_next;
    end

    // Checks
    assign chk_points_ok  = (points_reg < round_reg) || (round_reg == '1);
    assign chk_commit     = (state_reg == S_COMMIT) && slot_free;
    assign chk_out_idle   = m_valid_reg && (state_reg == S_IDLE);
    assign chk_found_idle = m_valid_reg && m_found_reg && (state_reg == S_IDLE);

    `UCBAS_ASSERT_SAME(a_round_nonzero, aclk, aresetn, 1'b1, round_reg != '0, "round is zero")
    `UCBAS_ASSERT_SAME(a_points_bound, aclk, aresetn, 1'b1, chk_points_ok, "points exceed rounds")
    `UCBAS_ASSERT_NEXT(a_commit_out, aclk, aresetn, chk_commit, chk_out_idle, "commit lost word")
    `UCBAS_ASSERT_SAME(a_found_pending, aclk, aresetn, chk_found_idle, pend_vld_reg, "no pending")

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// UCB bandit arm selector testbench
// Drives choose and reward words with random bursts and result stalls, keeps
// its own scoring model of the selector and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ucbas_pkg::*;

    localparam int NARMS    = 16;
    localparam int N_RANDOM = 530;
    localparam int WD_LIMIT = 40000;

    typedef struct packed {
        logic [3:0]  arm;
        logic        found;
        logic        accepted;
        logic [31:0] total;
    } outcome_t;

    typedef struct {
        logic     mode;
        logic     reward;
        logic     typed;
        outcome_t want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic        s_reward;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_arm;
    logic        m_arm_found;
    logic        m_reward_accepted;
    logic [31:0] m_total_reward;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // selector state as predicted
    logic [16:0] est_q[NARMS];
    logic [31:0] pulls[NARMS];
    logic [31:0] round_num;
    logic [31:0] points;
    logic [3:0]  pend_arm;
    logic        pend_ok;
    logic [15:0] gain;
    logic [4:0]  arms_on;

    outcome_t expected_words[$];
    row_t     plan[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       long_hold;
    bit       sent_all;

    ucb_bandit_arm_selector_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_reward(s_reward),
        .m_valid(m_valid), .m_ready(m_ready), .m_arm(m_arm),
        .m_arm_found(m_arm_found), .m_reward_accepted(m_reward_accepted),
        .m_total_reward(m_total_reward),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] log2_fix(input logic [31:0] x);
        logic [63:0] m;
        logic [15:0] fr;
        int          e;
        fr = '0;
        if (x == 0) return 64'd0;
        e = 31;
        while (!x[e]) e--;
        m = 64'(x) << (31 - e);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                fr[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(e) << 16) | 64'(fr);
    endfunction

    function automatic logic [63:0] root_fix(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic clear_selector();
        for (int i = 0; i < NARMS; i++) begin
            est_q[i] = EST_HALF;
            pulls[i] = '0;
        end
        round_num = 32'd1;
        points = '0;
        pend_arm = '0;
        pend_ok = 1'b0;
        gain = GAIN_RESET;
        arms_on = ARMS_RESET;
    endtask

    // score all active arms or apply a reward; returns the result word
    function automatic outcome_t select_or_update(input logic mode, input logic rew);
        outcome_t    o;
        logic [63:0] ln_v, q, s, score, best;
        logic [31:0] dv;
        logic [16:0] e;
        int          act, pick;
        bit          have;
        o = '0;
        if (mode == MODE_CHOOSE) begin
            act = (arms_on < NARMS) ? arms_on : NARMS;
            ln_v = (log2_fix(round_num) * 64'(LN2_Q16)) >> 16;
            best = 0;
            pick = 0;
            have = 0;
            for (int i = 0; i < act; i++) begin
                q = ln_v / (64'(pulls[i]) + 1);
                s = root_fix(q << 16);
                score = 64'(est_q[i]) + ((64'(gain) * s) >> 12);
                if (score > best) begin
                    best = score;
                    pick = i;
                    have = 1;
                end
            end
            if (have) begin
                if (pulls[pick] != 32'hFFFF_FFFF) pulls[pick]++;
                pend_arm = pick[3:0];
                pend_ok = 1'b1;
                o.arm = pick[3:0];
                o.found = 1'b1;
            end
        end else if (pend_ok) begin
            dv = (round_num == 0) ? 32'd1 : round_num;
            e = (est_q[pend_arm] > EST_ONE) ? EST_ONE : est_q[pend_arm];
            if (rew) begin
                e = e + 17'((EST_ONE - e) / dv);
                if (points != 32'hFFFF_FFFF) points++;
            end else begin
                e = e - 17'(e / dv);
            end
            est_q[pend_arm] = e;
            pend_ok = 1'b0;
            if (round_num != 32'hFFFF_FFFF) round_num++;
            o.accepted = 1'b1;
        end
        o.total = points;
        return o;
    endfunction

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_GAIN) gain = val;
        else arms_on = val[4:0];
    endtask

    // offer one word and hold it until taken
    task automatic send_word(input logic mode, input logic rew,
                             input logic typed, input outcome_t want);
        outcome_t o;
        s_valid = 1'b1;
        s_mode = mode;
        s_reward = rew;
        do @(posedge aclk); while (!s_ready);
        o = select_or_update(mode, rew);
        if (typed && o != want) begin
            $error("table row disagrees with prediction: %h vs %h", want, o);
            errors++;
        end
        expected_words = {expected_words, (typed ? want : o)};
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (3000) @(negedge aclk);
    endtask

    function automatic row_t mk(input logic md, input logic rw, input logic ty,
                                input logic [3:0] a, input logic f, input logic ac,
                                input logic [31:0] t);
        row_t r;
        r.mode = md;
        r.reward = rw;
        r.typed = ty;
        r.want = '{arm: a, found: f, accepted: ac, total: t};
        return r;
    endfunction

    // stimulus
    initial begin
        int burst;
        logic md;
        sent_all = 0;
        long_hold = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_CHOOSE;
        s_reward = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_GAIN;
        cfg_data = '0;
        clear_selector();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reward with nothing pending, first choice, rewards, replace
        plan = {plan, mk(MODE_REWARD, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 32'd0)};
        plan = {plan, mk(MODE_CHOOSE, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 32'd0)};
        plan = {plan, mk(MODE_REWARD, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 32'd1)};
        plan = {plan, mk(MODE_REWARD, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0, 32'd1)};
        plan = {plan, mk(MODE_CHOOSE, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 32'd0)};
        plan = {plan, mk(MODE_CHOOSE, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 32'd0)};
        plan = {plan, mk(MODE_REWARD, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 32'd0)};
        for (int i = 0; i < 6; i++)
            plan = {plan, mk(1'(i % 2), 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 32'd0)};
        foreach (plan[i]) send_word(plan[i].mode, plan[i].reward,
                                    plan[i].typed, plan[i].want);
        drain();

        // gain zero, one arm: estimates decide
        write_reg(CFG_GAIN, 16'd0);
        write_reg(CFG_ARMS, 16'd1);
        for (int i = 0; i < 4; i++) send_word(1'(i % 2), 1'b0, 1'b0, '0);
        drain();
        // no arms at all: no arm found
        write_reg(CFG_ARMS, 16'd0);
        send_word(MODE_CHOOSE, 1'b0, 1'b1,
                  '{arm: 4'd0, found: 1'b0, accepted: 1'b0, total: points});
        drain();
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_ARMS, 16'd31);
        for (int i = 0; i < 4; i++) send_word(1'(i % 2), 1'b1, 1'b0, '0);
        drain();

        // random phases with varying settings; mostly choose/reward pairs
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_GAIN, (ph == 4) ? 16'hFFFF : 16'($urandom));
            write_reg(CFG_ARMS, (ph == 0) ? 16'd16 : 16'($urandom_range(1, 6)));
            for (int n = 0; n < N_RANDOM / 5; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++) begin
                    if ($urandom_range(0, 9) < 8) md = n[0];
                    else md = 1'($urandom);
                    send_word(md, 1'($urandom), 1'b0, '0);
                end
                if (ph == 2 && n > 40 && !long_hold) long_hold = 1;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
            // pause until every result is back
            drain();
        end
        sent_all = 1;
    end

    // receiver stall pattern, with repeated long hold-offs once long_hold is set
    initial begin
        int pat;
        m_ready = 1'b0;
        pat = 0;
        forever begin
            @(negedge aclk);
            if (long_hold && pat >= 0) begin
                m_ready = 1'b0;
                repeat (3000) @(negedge aclk);
                pat = -1;
            end
            if (pat >= 0) pat++;
            if (pat < 0) pat = 1000;
            m_ready = ((pat / 50) % 3 == 0) ? 1'b1 : 1'($urandom_range(0, 2) != 0);
        end
    end

    // compare result words
    always @(posedge aclk) begin
        outcome_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                w = expected_words.pop_front();
                if (m_arm !== w.arm) begin
                    $error("arm: expected %0d actual %0d", w.arm, m_arm);
                    errors++;
                end
                if (m_arm_found !== w.found) begin
                    $error("arm_found: expected %0d actual %0d", w.found, m_arm_found);
                    errors++;
                end
                if (m_reward_accepted !== w.accepted) begin
                    $error("reward_accepted: expected %0d actual %0d",
                           w.accepted, m_reward_accepted);
                    errors++;
                end
                if (m_total_reward !== w.total) begin
                    $error("total_reward: expected %0d actual %0d", w.total, m_total_reward);
                    errors++;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (sent_all) begin
            if (errors == 0 && expected_words.size() == 0) $display("TB_OK");
            else $display("TB_ERROR");
            $finish;
        end
    end
endmodule

### ucb_bandit_arm_selector_top.f
+incdir+rtl
rtl/ucbas_pkg.sv
rtl/ucbas_ram.sv
rtl/ucb_bandit_arm_selector_top.sv
sim/tb_top.sv
